// ===== rtl/l4cs_pkg.sv =====
// Shared constants, types and the one's-complement adder for the L4 checksum fill block.
// No dependencies.
package l4cs_pkg;

    localparam logic [6:0]  ETH_HDR      = 7'd14;
    localparam logic [6:0]  MIN_LEN      = 7'd34;
    localparam logic [6:0]  HDR_SUM_LO   = 7'd26;
    localparam logic [6:0]  HDR_SUM_HI   = 7'd33;
    localparam logic [6:0]  POS_VER_IHL  = 7'd14;
    localparam logic [6:0]  POS_LEN_HI   = 7'd16;
    localparam logic [6:0]  POS_LEN_LO   = 7'd17;
    localparam logic [6:0]  POS_PROTO    = 7'd23;
    localparam logic [5:0]  MIN_HLEN     = 6'd20;
    localparam logic [3:0]  IP_VERSION   = 4'd4;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [4:0]  UDP_FIELD    = 5'd6;
    localparam logic [4:0]  TCP_FIELD    = 5'd16;
    localparam logic [15:0] CSUM_ALL_ONE = 16'hffff;

    typedef struct packed {
        logic        is_udp;
        logic [15:0] checksum;
        logic [10:0] field_offset;
        logic        apply;
    } t_result;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ===== rtl/ipv4_l4_checksum_fill.sv =====
// Top level of the IPv4 TCP/UDP checksum fill block: input register, per-byte
// header tracking and running sum, and the result register.
// Depends on l4cs_pkg.
//
// Usage:
//   s_axis carries one frame byte per item in tdata, Ethernet header first,
//   with tlast on the final byte. m_axis gives one result item per frame,
//   after its final byte: apply, the frame offset of the checksum high byte
//   and the checksum value in tdata, and the UDP flag in tuser.
//   Throughput: one byte per cycle, but a final byte stalls while a result
//   still waits. The accepted byte is held in an input register; the header
//   fields, the one's-complement sum and, on the final byte, the result are
//   registered from it (input register, then result register).
//   Reset clears the position, header fields, sum and both valid flags; the
//   block then waits for the first byte of a frame.
//   While a result waits on m_axis_tready, non-final bytes keep flowing; a
//   final byte waits in the input register until the result register frees.
//   Frames longer than MAX_FRAME bytes report apply = 0.
module ipv4_l4_checksum_fill #(
    parameter int MAX_FRAME = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] apply, [11:1] field_offset, [27:12] checksum
    output logic [0:0]  m_axis_tuser    // [0] is_udp
);

    localparam int PW = $clog2(MAX_FRAME + 1);

    logic                 r_a_valid;
    logic [7:0]           r_a_byte;
    logic                 r_a_last;
    logic                 r_out_valid;
    l4cs_pkg::t_result    r_out;

    logic [PW-1:0]        r_pos,      n_pos;
    logic [7:0]           r_vihl,     n_vihl;
    logic [15:0]          r_tlen,     n_tlen;
    logic [7:0]           r_proto,    n_proto;
    logic [15:0]          r_sum,      n_sum;
    logic                 r_too_long, n_too_long;

    logic                 w_adv;
    logic                 w_sat;
    logic [16:0]          w_p;
    logic [5:0]           w_hlen;
    logic [4:0]           w_fo;
    logic [16:0]          w_fpos;
    logic                 w_hdr_add;
    logic                 w_l4_add;
    logic [15:0]          w_val;

    logic [5:0]           w_hlen_f;
    logic [4:0]           w_fo_f;
    logic                 w_udp_f;
    logic [15:0]          w_l4len;
    logic                 w_ok;
    logic [15:0]          w_s1;
    logic [15:0]          w_s2;
    logic [15:0]          w_ck;
    l4cs_pkg::t_result    w_res;

    assign w_adv = r_a_valid && (!r_a_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || w_adv;

    always_comb begin
        w_sat  = r_pos >= PW'(MAX_FRAME);
        w_p    = 17'(r_pos);
        w_hlen = {r_vihl[3:0], 2'b00};
        w_fo   = (r_proto == l4cs_pkg::PROTO_UDP) ? l4cs_pkg::UDP_FIELD : l4cs_pkg::TCP_FIELD;
        w_fpos = 17'(l4cs_pkg::ETH_HDR) + 17'(w_hlen) + 17'(w_fo);
        w_hdr_add = (w_p >= 17'(l4cs_pkg::HDR_SUM_LO)) && (w_p <= 17'(l4cs_pkg::HDR_SUM_HI));
        w_l4_add  = (w_p >= 17'(l4cs_pkg::MIN_LEN)) && (w_hlen >= l4cs_pkg::MIN_HLEN)
                 && (r_tlen >= 16'(w_hlen))
                 && (w_p >= 17'(l4cs_pkg::ETH_HDR) + 17'(w_hlen))
                 && (w_p < 17'(r_tlen) + 17'(l4cs_pkg::ETH_HDR))
                 && (w_p != w_fpos) && (w_p != w_fpos + 17'd1);
        w_val = r_pos[0] ? {8'd0, r_a_byte} : {r_a_byte, 8'd0};

        n_pos      = w_sat ? r_pos : r_pos + PW'(1);
        n_too_long = r_too_long | w_sat;
        n_vihl     = (!w_sat && w_p == 17'(l4cs_pkg::POS_VER_IHL)) ? r_a_byte : r_vihl;
        n_tlen     = r_tlen;
        if (!w_sat && w_p == 17'(l4cs_pkg::POS_LEN_HI)) begin
            n_tlen[15:8] = r_a_byte;
        end
        if (!w_sat && w_p == 17'(l4cs_pkg::POS_LEN_LO)) begin
            n_tlen[7:0] = r_a_byte;
        end
        n_proto = (!w_sat && w_p == 17'(l4cs_pkg::POS_PROTO)) ? r_a_byte : r_proto;
        n_sum   = (!w_sat && (w_hdr_add || w_l4_add)) ? l4cs_pkg::oc_add(r_sum, w_val) : r_sum;
    end

    always_comb begin
        w_hlen_f = {n_vihl[3:0], 2'b00};
        w_udp_f  = n_proto == l4cs_pkg::PROTO_UDP;
        w_fo_f   = w_udp_f ? l4cs_pkg::UDP_FIELD : l4cs_pkg::TCP_FIELD;
        w_l4len  = n_tlen - 16'(w_hlen_f);
        w_ok = !n_too_long && (17'(n_pos) >= 17'(l4cs_pkg::MIN_LEN))
            && (n_vihl[7:4] == l4cs_pkg::IP_VERSION)
            && (w_udp_f || n_proto == l4cs_pkg::PROTO_TCP)
            && (w_hlen_f >= l4cs_pkg::MIN_HLEN) && (n_tlen >= 16'(w_hlen_f))
            && !(17'(n_tlen) + 17'(l4cs_pkg::ETH_HDR) > 17'(n_pos))
            && !(w_l4len < 16'(w_fo_f) + 16'd2);
        w_s1 = l4cs_pkg::oc_add(n_sum, {8'd0, n_proto});
        w_s2 = l4cs_pkg::oc_add(w_s1, w_l4len);
        w_ck = ~w_s2;
        if (w_ck == 16'd0 && w_udp_f) begin
            w_ck = l4cs_pkg::CSUM_ALL_ONE;
        end
        w_res = '0;
        if (w_ok) begin
            w_res.apply        = 1'b1;
            w_res.field_offset = 11'(l4cs_pkg::ETH_HDR) + 11'(w_hlen_f) + 11'(w_fo_f);
            w_res.checksum     = w_ck;
            w_res.is_udp       = w_udp_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_a_byte <= s_axis_tdata;
            r_a_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_vihl     <= '0;
            r_tlen     <= '0;
            r_proto    <= '0;
            r_sum      <= '0;
            r_too_long <= 1'b0;
        end else if (w_adv) begin
            if (r_a_last) begin
                r_pos      <= '0;
                r_vihl     <= '0;
                r_tlen     <= '0;
                r_proto    <= '0;
                r_sum      <= '0;
                r_too_long <= 1'b0;
            end else begin
                r_pos      <= n_pos;
                r_vihl     <= n_vihl;
                r_tlen     <= n_tlen;
                r_proto    <= n_proto;
                r_sum      <= n_sum;
                r_too_long <= n_too_long;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_a_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_adv && r_a_last) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.checksum, r_out.field_offset, r_out.apply};
    assign m_axis_tuser  = r_out.is_udp;

`ifndef SYNTH
    a_noop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.apply) |->
            (r_out.field_offset == 11'd0 && r_out.checksum == 16'd0 && !r_out.is_udp))
        else $error("no-op result carries nonzero fields");
    a_udp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.apply && r_out.is_udp) |-> (r_out.checksum != 16'd0))
        else $error("UDP checksum of zero sent");
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_a_last) |=> (r_pos == '0 && r_sum == 16'd0 && !r_too_long))
        else $error("frame state not cleared after final byte");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= PW'(MAX_FRAME)))
        else $error("byte position past saturation");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for ipv4_l4_checksum_fill: streams Ethernet frames byte by byte and
// compares every per-frame result against a byte-accurate checksum tracker kept here.
// Depends on l4cs_pkg and rtl/ipv4_l4_checksum_fill.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_LIMIT = 2048;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef enum int {
        DMG_SHORT, DMG_VERSION, DMG_PROTO, DMG_IHL, DMG_TLEN_LOW,
        DMG_TRUNC, DMG_L4_TINY, DMG_TLEN_ANY, DMG_GARBAGE, DMG_NONE
    } t_frame_damage;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [0] apply, [11:1] field_offset, [27:12] checksum
    logic [0:0]  m_axis_tuser;          // [0] is_udp

    t_byte_item         item_q [$];
    t_byte_item         tx_cur;
    l4cs_pkg::t_result  csum_expect_q [$];
    logic [7:0]  frm [];
    logic        s_took = 1'b0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          rx_hold_req = 1'b0;
    bit          rx_hold = 1'b0;
    int          bad_results = 0;
    int          result_cnt = 0;

    // checksum tracker state
    logic [11:0] trk_pos = '0;
    logic [7:0]  trk_ver_ihl = '0;
    logic [15:0] trk_tot_len = '0;
    logic [7:0]  trk_proto = '0;
    logic [15:0] trk_sum = '0;
    logic        trk_too_long = 1'b0;

    ipv4_l4_checksum_fill #(
        .MAX_FRAME(FRAME_LIMIT)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [15:0] ones_sum16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    task automatic sum_frame_byte(input int unsigned p, input logic [7:0] b);
        trk_sum = ones_sum16(trk_sum, p[0] ? {8'h00, b} : {b, 8'h00});
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int unsigned p, hlen, o, fo, l4, len;
        logic [15:0] s;
        bit          ok;
        l4cs_pkg::t_result r;
        if (trk_pos >= FRAME_LIMIT) begin
            trk_too_long = 1'b1;
        end else begin
            p = trk_pos;
            hlen = {trk_ver_ihl[3:0], 2'b00};
            if (p == l4cs_pkg::POS_VER_IHL) trk_ver_ihl = b;
            else if (p == l4cs_pkg::POS_LEN_HI) trk_tot_len[15:8] = b;
            else if (p == l4cs_pkg::POS_LEN_LO) trk_tot_len[7:0] = b;
            else if (p == l4cs_pkg::POS_PROTO) trk_proto = b;
            if (p >= l4cs_pkg::HDR_SUM_LO && p <= l4cs_pkg::HDR_SUM_HI) sum_frame_byte(p, b);
            if (p >= l4cs_pkg::MIN_LEN && hlen >= l4cs_pkg::MIN_HLEN && trk_tot_len >= hlen &&
                    p >= l4cs_pkg::ETH_HDR + hlen) begin
                o = p - l4cs_pkg::ETH_HDR - hlen;
                fo = (trk_proto == l4cs_pkg::PROTO_UDP) ? l4cs_pkg::UDP_FIELD
                                                         : l4cs_pkg::TCP_FIELD;
                if (o < trk_tot_len - hlen && o != fo && o != fo + 1) sum_frame_byte(p, b);
            end
            trk_pos = 12'(p + 1);
        end
        if (last) begin
            len = trk_pos;
            hlen = {trk_ver_ihl[3:0], 2'b00};
            ok = !trk_too_long && len >= l4cs_pkg::MIN_LEN &&
                 trk_ver_ihl[7:4] == l4cs_pkg::IP_VERSION &&
                 (trk_proto == l4cs_pkg::PROTO_TCP || trk_proto == l4cs_pkg::PROTO_UDP) &&
                 hlen >= l4cs_pkg::MIN_HLEN && trk_tot_len >= hlen;
            l4 = ok ? trk_tot_len - hlen : 0;
            fo = (trk_proto == l4cs_pkg::PROTO_UDP) ? l4cs_pkg::UDP_FIELD : l4cs_pkg::TCP_FIELD;
            if (ok && (l4cs_pkg::ETH_HDR + hlen + l4 > len || l4 < fo + 2)) ok = 1'b0;
            r = '0;
            if (ok) begin
                s = ones_sum16(trk_sum, {8'h00, trk_proto});
                s = ones_sum16(s, l4[15:0]);
                s = ~s;
                if (s == 16'd0 && trk_proto == l4cs_pkg::PROTO_UDP) s = l4cs_pkg::CSUM_ALL_ONE;
                r.apply = 1'b1;
                r.field_offset = 11'(l4cs_pkg::ETH_HDR + hlen + fo);
                r.checksum = s;
                r.is_udp = (trk_proto == l4cs_pkg::PROTO_UDP);
            end
            csum_expect_q.push_back(r);
            trk_pos = '0;
            trk_ver_ihl = '0;
            trk_tot_len = '0;
            trk_proto = '0;
            trk_sum = '0;
            trk_too_long = 1'b0;
        end
    endtask

    task automatic frame_init(input int unsigned len, input int fill);
        frm = new[len];
        foreach (frm[i]) frm[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    endtask

    task automatic frame_set(input logic [7:0] vihl, input logic [15:0] tlen,
                             input logic [7:0] pr);
        if (frm.size() > l4cs_pkg::POS_VER_IHL) frm[l4cs_pkg::POS_VER_IHL] = vihl;
        if (frm.size() > l4cs_pkg::POS_LEN_HI) frm[l4cs_pkg::POS_LEN_HI] = tlen[15:8];
        if (frm.size() > l4cs_pkg::POS_LEN_LO) frm[l4cs_pkg::POS_LEN_LO] = tlen[7:0];
        if (frm.size() > l4cs_pkg::POS_PROTO) frm[l4cs_pkg::POS_PROTO] = pr;
    endtask

    task automatic frame_push();
        foreach (frm[i]) item_q.push_back('{data: frm[i], last: (i == frm.size() - 1)});
    endtask

    task automatic queue_random_frame(output int unsigned n);
        logic [3:0]    ver, ihl;
        logic [7:0]    pr;
        logic [15:0]   tlen;
        int unsigned   hlen, fo, l4, pad, len;
        t_frame_damage dmg;
        ver = l4cs_pkg::IP_VERSION;
        pr = $urandom_range(1) ? l4cs_pkg::PROTO_UDP : l4cs_pkg::PROTO_TCP;
        ihl = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
        hlen = {ihl, 2'b00};
        fo = (pr == l4cs_pkg::PROTO_UDP) ? l4cs_pkg::UDP_FIELD : l4cs_pkg::TCP_FIELD;
        l4 = $urandom_range(32, fo + 2);
        pad = ($urandom_range(3) == 0) ? $urandom_range(20, 1) : 0;
        tlen = 16'(hlen + l4);
        len = l4cs_pkg::ETH_HDR + hlen + l4 + pad;
        dmg = ($urandom_range(99) < 25) ? t_frame_damage'($urandom_range(DMG_GARBAGE)) : DMG_NONE;
        case (dmg)
            DMG_SHORT: len = $urandom_range(l4cs_pkg::MIN_LEN - 1, 1);
            DMG_VERSION: begin
                ver = 4'($urandom_range(14));
                if (ver >= l4cs_pkg::IP_VERSION) ver = ver + 4'd1;
            end
            DMG_PROTO: begin
                pr = 8'($urandom_range(255));
                if (pr == l4cs_pkg::PROTO_TCP || pr == l4cs_pkg::PROTO_UDP) pr = ~pr;
            end
            DMG_IHL: ihl = 4'($urandom_range(4));
            DMG_TLEN_LOW: tlen = 16'($urandom_range(hlen - 1));
            DMG_TRUNC: len = l4cs_pkg::ETH_HDR + hlen + $urandom_range(l4 - 1);
            DMG_L4_TINY: begin
                l4 = $urandom_range(fo + 1);
                tlen = 16'(hlen + l4);
                len = l4cs_pkg::ETH_HDR + hlen + l4 + pad;
            end
            DMG_TLEN_ANY: tlen = 16'($urandom);
            DMG_GARBAGE: len = $urandom_range(80, 1);
            default: ;
        endcase
        frame_init(len, -1);
        if (dmg != DMG_GARBAGE) frame_set({ver, ihl}, tlen, pr);
        frame_push();
        n = len;
    endtask

    task automatic random_frames(input int unsigned byte_goal, input int unsigned frame_goal);
        int unsigned nb, nf, n;
        nb = 0;
        nf = 0;
        while (nb < byte_goal || nf < frame_goal) begin
            queue_random_frame(n);
            nb += n;
            nf++;
        end
    endtask

    task automatic drain_results();
        while (item_q.size() != 0 || s_axis_tvalid || csum_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // sender: advance on accept or when idle
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || s_took) begin
            if (i_rst_n && item_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                tx_cur = item_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= tx_cur.data;
                s_axis_tlast <= tx_cur.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        wait (rx_hold_req);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) begin
        l4cs_pkg::t_result want, got;
        s_took <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) absorb_byte(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser[0], m_axis_tdata[27:0]};
            result_cnt++;
            if (csum_expect_q.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("result %0d: unexpected, got apply=%0d off=%0d csum=%h udp=%0d",
                             result_cnt, got.apply, got.field_offset, got.checksum, got.is_udp);
            end else begin
                want = csum_expect_q.pop_front();
                if (got.apply !== want.apply || got.field_offset !== want.field_offset ||
                        got.checksum !== want.checksum || got.is_udp !== want.is_udp) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("result %0d: want apply=%0d off=%0d csum=%h udp=%0d",
                                 result_cnt, want.apply, want.field_offset, want.checksum,
                                 want.is_udp);
                        $display("result %0d: got  apply=%0d off=%0d csum=%h udp=%0d",
                                 result_cnt, got.apply, got.field_offset, got.checksum,
                                 got.is_udp);
                    end
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        tx_idle_pct = 32;
        rx_idle_pct = 78;

        frame_init(42, -1);   frame_set(8'h45, 16'd28, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(54, -1);   frame_set(8'h45, 16'd40, l4cs_pkg::PROTO_TCP);   frame_push();
        // UDP sum that inverts to zero goes out as all ones
        frame_init(44, 0);    frame_set(8'h45, 16'd30, l4cs_pkg::PROTO_UDP);
        frm[42] = 8'hff;      frm[43] = 8'he4;                                 frame_push();
        // TCP keeps a zero checksum
        frame_init(54, 0);    frame_set(8'h45, 16'd40, l4cs_pkg::PROTO_TCP);
        frm[52] = 8'hff;      frm[53] = 8'he5;                                 frame_push();
        frame_init(64, 255);  frame_set(8'h45, 16'd50, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(98, -1);   frame_set(8'h4f, 16'd84, l4cs_pkg::PROTO_TCP);   frame_push();
        frame_init(43, -1);   frame_set(8'h45, 16'd29, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(60, -1);   frame_set(8'h45, 16'd28, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(33, -1);   frame_set(8'h45, 16'd28, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(1, -1);                                                     frame_push();
        frame_init(34, -1);   frame_set(8'h45, 16'd20, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(42, -1);   frame_set(8'h65, 16'd28, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(42, -1);   frame_set(8'h44, 16'd28, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(54, -1);   frame_set(8'h40, 16'd28, l4cs_pkg::PROTO_TCP);   frame_push();
        frame_init(42, -1);   frame_set(8'h45, 16'd28, 8'h01);                 frame_push();
        frame_init(42, -1);   frame_set(8'h45, 16'd28, 8'hff);                 frame_push();
        frame_init(42, -1);   frame_set(8'h45, 16'd19, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(41, -1);   frame_set(8'h45, 16'd28, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(41, -1);   frame_set(8'h45, 16'd27, l4cs_pkg::PROTO_UDP);   frame_push();
        frame_init(51, -1);   frame_set(8'h45, 16'd37, l4cs_pkg::PROTO_TCP);   frame_push();
        frame_init(60, -1);   frame_set(8'h45, 16'hffff, l4cs_pkg::PROTO_TCP); frame_push();
        drain_results();

        random_frames(170, 3);
        drain_results();

        tx_idle_pct = 78;
        rx_idle_pct = 32;
        random_frames(170, 3);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        random_frames(170, 3);
        drain_results();

        repeat (8) @(posedge i_clk);
        if (bad_results == 0 && csum_expect_q.size() == 0) begin
            $display("ipv4_l4_checksum_fill verification clean");
        end else begin
            $display("ipv4_l4_checksum_fill verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("ipv4_l4_checksum_fill verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/l4cs_pkg.sv
rtl/ipv4_l4_checksum_fill.sv
tb/sv/tb.sv
